// File: sv/xsrg_pkg.sv
package xsrg_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam logic [DataW-1:0] MultConst = 64'h2545_F491_4F6C_DD1D;
  localparam logic [DataW-1:0] SeedReset = 64'd1;
  localparam int unsigned ShiftA = 12;
  localparam int unsigned ShiftB = 25;
  localparam int unsigned ShiftC = 27;

  localparam int unsigned QueueDepthDefault = 2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED  = 2'd0,
    CFG_LOW   = 2'd1,
    CFG_HIGH  = 2'd2
  } xsrg_cfg_e;

  // how the back end treats a raw value
  typedef enum logic [1:0] {
    CLS_RAW = 2'd0,
    CLS_ERR = 2'd1,
    CLS_MOD = 2'd2
  } xsrg_cls_e;

  typedef struct packed {
    logic [DataW-1:0] raw;
    logic [DataW-1:0] span;
    logic [DataW-1:0] low;
    xsrg_cls_e        cls;
  } xsrg_entry_t;

  // a zero seed would lock the generator
  function automatic logic [DataW-1:0] load_seed(input logic [DataW-1:0] s);
    return (s == '0) ? SeedReset : s;
  endfunction

  function automatic logic [DataW-1:0] xorshift(input logic [DataW-1:0] s);
    logic [DataW-1:0] x;
    x = s;
    x = x ^ (x >> ShiftA);
    x = x ^ (x << ShiftB);
    x = x ^ (x >> ShiftC);
    return x;
  endfunction

endpackage

// File: sv/xsrg_front.sv
module xsrg_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 restart_i,
  input  logic [xsrg_pkg::DataW-1:0]           seed_i,
  input  logic [xsrg_pkg::DataW-1:0]           low_i,
  input  logic [xsrg_pkg::DataW-1:0]           high_i,
  output logic                                 push_o,
  output xsrg_pkg::xsrg_entry_t                entry_o,
  input  logic                                 full_i
);

  localparam int unsigned W = xsrg_pkg::DataW;
  localparam int unsigned H = xsrg_pkg::HalfW;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL0 = 6'b000010,
    F_MUL1 = 6'b000100,
    F_MUL2 = 6'b001000,
    F_MUL3 = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_e;

  front_state_e fsm_q, fsm_d;

  logic [W-1:0] gen_q, gen_d;
  logic [W-1:0] acc_q;
  logic [W-1:0] prod_q;
  logic [W-1:0] span_q;
  logic [W-1:0] low_q;
  xsrg_pkg::xsrg_cls_e cls_q;

  logic [H-1:0] mul_a, mul_b;
  logic [W-1:0] span_w;
  logic         accept;

  assign accept     = in_valid_i && (fsm_q == F_IDLE);
  assign in_stall_o = (fsm_q != F_IDLE);
  assign span_w     = high_i - low_i;

  always_comb begin
    gen_d = gen_q;
    if (accept) begin
      gen_d = xsrg_pkg::xorshift(restart_i ? xsrg_pkg::load_seed(seed_i) : gen_q);
    end
  end

  // 64x64 low product from one 32x32 multiplier: lo*lo, then the two cross terms
  assign mul_a = (fsm_q == F_MUL2) ? gen_q[W-1:H] : gen_q[H-1:0];
  assign mul_b = (fsm_q == F_MUL1) ? xsrg_pkg::MultConst[W-1:H]
                                   : xsrg_pkg::MultConst[H-1:0];

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      F_IDLE: if (accept) fsm_d = F_MUL0;
      F_MUL0: fsm_d = F_MUL1;
      F_MUL1: fsm_d = F_MUL2;
      F_MUL2: fsm_d = F_MUL3;
      F_MUL3: fsm_d = F_PUSH;
      F_PUSH: if (!full_i) fsm_d = F_IDLE;
      default: fsm_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= F_IDLE;
      gen_q <= xsrg_pkg::SeedReset;
    end else begin
      fsm_q <= fsm_d;
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= W'(mul_a) * W'(mul_b);
    unique case (fsm_q) inside
      F_MUL1: acc_q <= prod_q;
      F_MUL2, F_MUL3: acc_q <= acc_q + {prod_q[H-1:0], {H{1'b0}}};
      default: acc_q <= acc_q;
    endcase
    if (accept) begin
      span_q <= span_w;
      low_q  <= low_i;
      if (low_i == '0 && high_i == '0) begin
        cls_q <= xsrg_pkg::CLS_RAW;
      end else if (span_w == '0) begin
        cls_q <= xsrg_pkg::CLS_ERR;
      end else begin
        cls_q <= xsrg_pkg::CLS_MOD;
      end
    end
  end

  assign push_o       = (fsm_q == F_PUSH) && !full_i;
  assign entry_o.raw  = acc_q;
  assign entry_o.span = span_q;
  assign entry_o.low  = low_q;
  assign entry_o.cls  = cls_q;

endmodule

// File: sv/xsrg_fifo.sv
module xsrg_fifo #(
  parameter int unsigned Depth = xsrg_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  xsrg_pkg::xsrg_entry_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output xsrg_pkg::xsrg_entry_t data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  xsrg_pkg::xsrg_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/xsrg_back.sv
module xsrg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  input  xsrg_pkg::xsrg_entry_t             entry_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [xsrg_pkg::DataW-1:0]        random_value_o,
  output logic                              range_error_o
);

  localparam int unsigned W = xsrg_pkg::DataW;
  localparam int unsigned CW = xsrg_pkg::CntW;
  localparam logic [CW-1:0] LastStep = CW'(W - 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_ADD  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_e;

  back_state_e fsm_q, fsm_d;

  logic [W-1:0]  rem_q, dvd_q, div_q, low_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  res_val_q;
  logic          res_err_q;
  logic          out_valid_q;
  logic [W-1:0]  out_val_q;
  logic          out_err_q;

  logic [W:0]    trial;
  logic          fits;
  logic          out_load;

  assign pop_o    = (fsm_q == B_IDLE) && !empty_i;
  assign out_load = (fsm_q == B_DONE) && (!out_valid_q || !out_stall_i);

  // restoring division, one quotient bit per cycle; only the remainder is kept
  assign trial = {rem_q, dvd_q[W-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      B_IDLE: begin
        if (pop_o) begin
          fsm_d = (entry_i.cls == xsrg_pkg::CLS_MOD) ? B_DIV : B_DONE;
        end
      end
      B_DIV:  if (cnt_q == LastStep) fsm_d = B_ADD;
      B_ADD:  fsm_d = B_DONE;
      B_DONE: if (out_load) fsm_d = B_IDLE;
      default: fsm_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == B_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (fsm_q)
      B_IDLE: begin
        if (pop_o) begin
          rem_q <= '0;
          dvd_q <= entry_i.raw;
          div_q <= entry_i.span;
          low_q <= entry_i.low;
          res_err_q <= (entry_i.cls == xsrg_pkg::CLS_ERR);
          res_val_q <= (entry_i.cls == xsrg_pkg::CLS_RAW) ? entry_i.raw : '0;
        end
      end
      B_DIV: begin
        rem_q <= fits ? W'(trial - {1'b0, div_q}) : trial[W-1:0];
        dvd_q <= dvd_q << 1;
      end
      B_ADD: res_val_q <= rem_q + low_q;
      default: ;
    endcase
    if (out_load) begin
      out_val_q <= res_val_q;
      out_err_q <= res_err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_val_q;
  assign range_error_o  = out_err_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == B_DIV |-> div_q != '0)
    else $error("divider running with zero divisor");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == B_ADD |-> rem_q < div_q)
    else $error("remainder not below divisor");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_err_q |-> res_val_q == '0)
    else $error("range error with nonzero value");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == B_ADD |-> $past(fsm_q) == B_DIV && $past(cnt_q) == LastStep)
    else $error("division left early");

endmodule

// File: sv/xorshift64star_ranged_generator_unit.sv
// xorshift64* generator with optional range reduction. Each transaction on the
// input side steps the 64-bit state (reloaded from the seed register first when
// restart_i is set) and yields one result. The front end takes a transaction,
// steps the state and forms the 64-bit product with one 32x32 multiplier; it
// hands the raw value to a small queue and is free again once the queue has
// taken it. The back end passes raw values and range errors straight to the
// output register, and otherwise reduces through a one-bit-per-cycle restoring
// divider followed by the final add and the output register. The output
// register lets a finished result wait while the next transaction is already
// being worked on. Configuration writes (seed, low, high) are to be made only
// while the unit is idle; a seed write takes effect on the next restart.
module xorshift64star_ranged_generator_unit #(
  parameter int unsigned QueueDepth = xsrg_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [xsrg_pkg::DataW-1:0]     random_value_o,
  output logic                           range_error_o,
  input  logic                           cfg_we_i,
  input  logic [xsrg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [xsrg_pkg::DataW-1:0]     cfg_data_i
);

  logic [xsrg_pkg::DataW-1:0] seed_q, low_q, high_q;

  logic                  push, pop, full, empty;
  xsrg_pkg::xsrg_entry_t push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= xsrg_pkg::SeedReset;
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        xsrg_pkg::CFG_SEED: seed_q <= cfg_data_i;
        xsrg_pkg::CFG_LOW:  low_q  <= cfg_data_i;
        xsrg_pkg::CFG_HIGH: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  xsrg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .seed_i     (seed_q),
    .low_i      (low_q),
    .high_i     (high_q),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  xsrg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  xsrg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o),
    .range_error_o  (range_error_o)
  );

endmodule
